// File: rtl/urxf_pkg.sv
// Shared types and constants for the UART receive FIFO with parity filter.
// Used by uart_rx_fifo_parity_filter_top; depends on nothing else.
`timescale 1ns / 1ps

package urxf_pkg;

	// FIFO geometry: depth must be a power of two
	localparam int FIFO_DEPTH = 16;
	localparam int ADDR_W     = $clog2(FIFO_DEPTH);
	localparam int PTR_W      = ADDR_W + 1;

	// Configuration port geometry
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 1;

	// Configuration register indexes
	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_ENABLE        = 2'd0,
		CFG_PARITY_ENABLE = 2'd1,
		CFG_PARITY_ODD    = 2'd2
	} cfg_index_t;

	// Item operation codes
	typedef enum logic {
		OP_RECEIVE = 1'b0,
		OP_READ    = 1'b1
	} op_t;

	// Result status codes
	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_EMPTY    = 3'd1,
		ST_DISABLED = 3'd2,
		ST_PARITY   = 3'd3,
		ST_FULL     = 3'd4
	} status_t;

	// One input beat
	typedef struct packed {
		logic       op;
		logic [7:0] rx_byte;
		logic       rx_parity_bit;
	} in_item_t;

	// One result beat
	typedef struct packed {
		logic [7:0] read_data;
		logic [2:0] status;
		logic       overflow;
		logic [4:0] fill_level;
	} out_item_t;

endpackage

// File: rtl/uart_rx_fifo_parity_filter_top.sv
// Top level of the UART receive FIFO with parity filter.
// Depends on urxf_pkg for item types, status codes and FIFO geometry.
`timescale 1ns / 1ps

// Receive-side byte FIFO of a UART, 16 entries deep. A receive beat (op 0)
// pushes its byte when the block is enabled and the FIFO has room; with
// parity checking on, a byte whose parity bit does not match even or odd
// parity over all 8 data bits is dropped. A receive into a full FIFO sets a
// sticky overflow flag that only reset clears. A read beat (op 1) pops the
// oldest byte or reports empty; while disabled, both are refused. Every
// input beat yields exactly one result beat carrying data, status, the
// overflow flag and the fill level after the beat. A beat is registered on
// entry, processed against the FIFO from that input stage and lands in the
// result register; one beat is accepted per cycle while the result side
// keeps up, and the result register frees the input side whenever its beat is taken.
// Configuration writes take effect at once, so write them only while no
// beat is in flight.
module uart_rx_fifo_parity_filter_top (
	input  logic                                clk,
	input  logic                                arst_n,
	// input channel
	input  logic                                item_valid,
	output logic                                item_stall,
	input  urxf_pkg::in_item_t                  item,
	// result channel
	output logic                                result_valid,
	input  logic                                result_stall,
	output urxf_pkg::out_item_t                 result,
	// configuration write port
	input  logic                                cfg_we,
	input  logic [urxf_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [urxf_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

	// configuration registers
	logic enable_q;
	logic parity_enable_q;
	logic parity_odd_q;

	// FIFO state
	logic [7:0]                   mem_q [urxf_pkg::FIFO_DEPTH];
	logic [urxf_pkg::PTR_W-1:0]   wr_ptr_q;
	logic [urxf_pkg::PTR_W-1:0]   rd_ptr_q;
	logic                         overflow_q;

	// input stage
	logic                         valid_s1;
	urxf_pkg::in_item_t           item_s1;

	// result register
	logic                         out_valid_q;
	urxf_pkg::out_item_t          out_q;

	// processing logic
	logic                         advance;
	logic [urxf_pkg::PTR_W-1:0]   fill;
	logic                         full;
	logic                         empty;
	logic                         parity_ok;
	logic                         do_push;
	logic                         do_pop;
	logic                         set_overflow;
	urxf_pkg::status_t            status;
	logic [7:0]                   read_data;
	logic [urxf_pkg::PTR_W-1:0]   fill_next;

	// the stage advances when the result register is free or being taken
	assign advance    = !out_valid_q || !result_stall;
	assign item_stall = valid_s1 && !advance;

	// write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q        <= 1'b1;
			parity_enable_q <= 1'b0;
			parity_odd_q    <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				urxf_pkg::CFG_ENABLE:        enable_q        <= cfg_wdata[0];
				urxf_pkg::CFG_PARITY_ENABLE: parity_enable_q <= cfg_wdata[0];
				urxf_pkg::CFG_PARITY_ODD:    parity_odd_q    <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// capture an input beat whenever the stage is empty or moving on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
	end

	// decide push, pop and status for the staged beat
	assign fill      = wr_ptr_q - rd_ptr_q;
	assign full      = (fill == urxf_pkg::PTR_W'(urxf_pkg::FIFO_DEPTH));
	assign empty     = (fill == '0);
	assign parity_ok = !parity_enable_q ||
		((^item_s1.rx_byte ^ parity_odd_q) == item_s1.rx_parity_bit);

	always_comb begin
		do_push      = 1'b0;
		do_pop       = 1'b0;
		set_overflow = 1'b0;
		status       = urxf_pkg::ST_OK;
		if (!enable_q) begin
			status = urxf_pkg::ST_DISABLED;
		end else if (item_s1.op == urxf_pkg::OP_RECEIVE) begin
			if (full) begin
				set_overflow = 1'b1;
				status       = urxf_pkg::ST_FULL;
			end else if (!parity_ok) begin
				status = urxf_pkg::ST_PARITY;
			end else begin
				do_push = 1'b1;
			end
		end else begin
			if (empty) begin
				status = urxf_pkg::ST_EMPTY;
			end else begin
				do_pop = 1'b1;
			end
		end
	end

	assign read_data = do_pop ? mem_q[rd_ptr_q[urxf_pkg::ADDR_W-1:0]] : 8'd0;
	assign fill_next = fill + urxf_pkg::PTR_W'(do_push) - urxf_pkg::PTR_W'(do_pop);

	// update FIFO pointers and the sticky overflow flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
			overflow_q <= 1'b0;
		end else if (valid_s1 && advance) begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + urxf_pkg::PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + urxf_pkg::PTR_W'(1);
			end
			if (set_overflow) begin
				overflow_q <= 1'b1;
			end
		end
	end

	// store the pushed byte
	always_ff @(posedge clk) begin
		if (valid_s1 && advance && do_push) begin
			mem_q[wr_ptr_q[urxf_pkg::ADDR_W-1:0]] <= item_s1.rx_byte;
		end
	end

	// hold the result beat until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			out_q.read_data  <= read_data;
			out_q.status     <= status;
			out_q.overflow   <= overflow_q || set_overflow;
			out_q.fill_level <= 5'(fill_next);
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

// File: verif/uart_rx_fifo_parity_filter_top_test.sv
// Self-checking testbench for the UART receive FIFO with parity filter.
// Depends on urxf_pkg and uart_rx_fifo_parity_filter_top; drives beats from a queue
// and checks every result beat against an in-bench FIFO and parity predictor.
`timescale 1ns / 1ps

module uart_rx_fifo_parity_filter_top_test;

	logic                             clk          = 1'b0;
	logic                             arst_n       = 1'b0;
	logic                             item_valid   = 1'b0;
	logic                             item_stall;
	urxf_pkg::in_item_t               item         = '0;
	logic                             result_valid;
	logic                             result_stall = 1'b0;
	urxf_pkg::out_item_t              result;
	logic                             cfg_we       = 1'b0;
	logic [urxf_pkg::CFG_INDEX_W-1:0] cfg_index    = '0;
	logic [urxf_pkg::CFG_DATA_W-1:0]  cfg_wdata    = '0;

	uart_rx_fifo_parity_filter_top DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata)
	);

	// Beats waiting to go out, and results predicted for accepted beats
	urxf_pkg::in_item_t  beats_to_send[$];
	urxf_pkg::out_item_t predicted_results[$];

	// Mirror of the FIFO and its registers
	logic [7:0]                 mirror_store [urxf_pkg::FIFO_DEPTH];
	logic [urxf_pkg::PTR_W-1:0] mirror_wr_ptr = '0;
	logic [urxf_pkg::PTR_W-1:0] mirror_rd_ptr = '0;
	logic                       mirror_ovf    = 1'b0;
	logic                       cfg_en        = 1'b1;
	logic                       cfg_par_en    = 1'b0;
	logic                       cfg_par_odd   = 1'b0;

	// Run bookkeeping
	logic no_idle         = 1'b0;
	int   fail_count      = 0;
	int   beats_sent      = 0;
	int   results_checked = 0;
	int   parity_drops    = 0;
	int   full_hits       = 0;
	int   settings_used   = 0;

	// Free-running clock
	initial begin
		forever #10 clk = ~clk;
	end

	// Advance the mirror by one beat and return the result it should produce
	function automatic urxf_pkg::out_item_t predict_fifo_result(urxf_pkg::in_item_t b);
		urxf_pkg::out_item_t        r;
		logic [urxf_pkg::PTR_W-1:0] fill;
		r    = '0;
		fill = mirror_wr_ptr - mirror_rd_ptr;
		if (!cfg_en) begin
			r.status = urxf_pkg::ST_DISABLED;
		end else if (b.op == urxf_pkg::OP_RECEIVE) begin
			// fill check wins over the parity check
			if (fill < urxf_pkg::PTR_W'(urxf_pkg::FIFO_DEPTH)) begin
				if (cfg_par_en && (((^b.rx_byte) ^ cfg_par_odd) != b.rx_parity_bit)) begin
					r.status = urxf_pkg::ST_PARITY;
				end else begin
					mirror_store[mirror_wr_ptr[urxf_pkg::ADDR_W-1:0]] = b.rx_byte;
					mirror_wr_ptr = mirror_wr_ptr + urxf_pkg::PTR_W'(1);
				end
			end else begin
				mirror_ovf = 1'b1;
				r.status   = urxf_pkg::ST_FULL;
			end
		end else if (fill != '0) begin
			r.read_data   = mirror_store[mirror_rd_ptr[urxf_pkg::ADDR_W-1:0]];
			mirror_rd_ptr = mirror_rd_ptr + urxf_pkg::PTR_W'(1);
		end else begin
			r.status = urxf_pkg::ST_EMPTY;
		end
		r.overflow   = mirror_ovf;
		r.fill_level = 5'(mirror_wr_ptr - mirror_rd_ptr);
		return r;
	endfunction

	// Driver: predict each accepted beat, hold a stalled one, idle at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else begin
			if (item_valid && !item_stall) begin
				predicted_results.push_back(predict_fifo_result(item));
				beats_sent++;
			end
			if (!item_valid || !item_stall) begin
				if (beats_to_send.size() != 0 && (no_idle || $urandom_range(99) >= 37)) begin
					item       <= beats_to_send.pop_front();
					item_valid <= 1'b1;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: compare each taken result beat with the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		urxf_pkg::out_item_t want;
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else begin
			if (result_valid && !result_stall) begin
				if (predicted_results.size() == 0) begin
					$error("result beat with no prediction pending: %h", result);
					fail_count++;
				end else begin
					want = predicted_results.pop_front();
					results_checked++;
					if (want.status == urxf_pkg::ST_PARITY)
						parity_drops++;
					if (want.status == urxf_pkg::ST_FULL)
						full_hits++;
					if (result.read_data !== want.read_data) begin
						$error("read_data: expected %0h, got %0h", want.read_data,
							result.read_data);
						fail_count++;
					end
					if (result.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, result.status);
						fail_count++;
					end
					if (result.overflow !== want.overflow) begin
						$error("overflow: expected %0b, got %0b", want.overflow,
							result.overflow);
						fail_count++;
					end
					if (result.fill_level !== want.fill_level) begin
						$error("fill_level: expected %0d, got %0d", want.fill_level,
							result.fill_level);
						fail_count++;
					end
				end
			end
			result_stall <= no_idle ? 1'b0 : ($urandom_range(99) < 37);
		end
	end

	task automatic add_beat(urxf_pkg::op_t op, logic [7:0] data, logic pbit);
		urxf_pkg::in_item_t b;
		b.op            = op;
		b.rx_byte       = data;
		b.rx_parity_bit = pbit;
		beats_to_send.push_back(b);
	endtask

	// Wait until every beat is sent and answered, then let the pipeline empty
	task automatic drain_block();
		while (beats_to_send.size() != 0 || item_valid || predicted_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(urxf_pkg::cfg_index_t idx, logic val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			urxf_pkg::CFG_ENABLE:        cfg_en      = val;
			urxf_pkg::CFG_PARITY_ENABLE: cfg_par_en  = val;
			urxf_pkg::CFG_PARITY_ODD:    cfg_par_odd = val;
			default: ;
		endcase
	endtask

	task automatic apply_setting(logic en, logic par_en, logic par_odd);
		drain_block();
		write_reg(urxf_pkg::CFG_ENABLE, en);
		write_reg(urxf_pkg::CFG_PARITY_ENABLE, par_en);
		write_reg(urxf_pkg::CFG_PARITY_ODD, par_odd);
		settings_used++;
	endtask

	// Mostly fill and drain bursts with good parity, plus some noise beats
	task automatic queue_random_traffic(int count);
		int         queued;
		int         kind;
		int         len;
		logic [7:0] data;
		logic       pbit;
		queued = 0;
		while (queued < count) begin
			kind = $urandom_range(9);
			if (kind <= 3) begin
				len = $urandom_range(20, 1);
				for (int i = 0; i < len; i++) begin
					data = 8'($urandom);
					pbit = (^data) ^ cfg_par_odd;
					if ($urandom_range(9) == 0)
						pbit = ~pbit;
					add_beat(urxf_pkg::OP_RECEIVE, data, pbit);
				end
				queued += len;
			end else if (kind <= 6) begin
				len = $urandom_range(20, 1);
				for (int i = 0; i < len; i++)
					add_beat(urxf_pkg::OP_READ, 8'($urandom), 1'($urandom));
				queued += len;
			end else begin
				add_beat(urxf_pkg::op_t'($urandom_range(1)), 8'($urandom), 1'($urandom));
				queued++;
			end
		end
	endtask

	// Stimulus sequence
	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: empty read, byte extremes, drain back to empty
		add_beat(urxf_pkg::OP_READ, 8'h00, 1'b0);
		add_beat(urxf_pkg::OP_RECEIVE, 8'h00, 1'b1);
		add_beat(urxf_pkg::OP_RECEIVE, 8'hFF, 1'b0);
		add_beat(urxf_pkg::OP_RECEIVE, 8'hA5, 1'b1);
		add_beat(urxf_pkg::OP_READ, 8'hFF, 1'b1);
		add_beat(urxf_pkg::OP_READ, 8'h00, 1'b0);
		add_beat(urxf_pkg::OP_READ, 8'h5A, 1'b1);
		add_beat(urxf_pkg::OP_READ, 8'h00, 1'b0);
		settings_used++;

		// Even parity: matching bytes kept, mismatching ones dropped
		apply_setting(1'b1, 1'b1, 1'b0);
		add_beat(urxf_pkg::OP_RECEIVE, 8'h00, 1'b0);
		add_beat(urxf_pkg::OP_RECEIVE, 8'h00, 1'b1);
		add_beat(urxf_pkg::OP_RECEIVE, 8'h07, 1'b1);
		add_beat(urxf_pkg::OP_RECEIVE, 8'h07, 1'b0);
		add_beat(urxf_pkg::OP_READ, 8'h00, 1'b0);
		add_beat(urxf_pkg::OP_READ, 8'h00, 1'b0);

		// Odd parity
		apply_setting(1'b1, 1'b1, 1'b1);
		add_beat(urxf_pkg::OP_RECEIVE, 8'h00, 1'b1);
		add_beat(urxf_pkg::OP_RECEIVE, 8'h00, 1'b0);
		add_beat(urxf_pkg::OP_RECEIVE, 8'hFF, 1'b1);
		add_beat(urxf_pkg::OP_READ, 8'h00, 1'b0);
		add_beat(urxf_pkg::OP_READ, 8'h00, 1'b0);

		// Disabled: receive and read both refused, a byte left in the FIFO
		add_beat(urxf_pkg::OP_RECEIVE, 8'h3C, 1'b1);
		apply_setting(1'b0, 1'b0, 1'b0);
		add_beat(urxf_pkg::OP_RECEIVE, 8'h81, 1'b0);
		add_beat(urxf_pkg::OP_READ, 8'h00, 1'b0);

		// Random traffic across settings; the first phase runs without idling
		for (int phase = 0; phase < 8; phase++) begin
			case (phase)
				0:       apply_setting(1'b1, 1'b0, 1'b0);
				1:       apply_setting(1'b1, 1'b1, 1'b0);
				2:       apply_setting(1'b1, 1'b1, 1'b1);
				4:       apply_setting(1'b0, 1'b1, 1'b1);
				default: apply_setting(1'b1, 1'($urandom), 1'($urandom));
			endcase
			no_idle = (phase == 0);
			queue_random_traffic((phase == 4) ? 15 : 55);
		end
		drain_block();
		no_idle = 1'b0;
		repeat (10) @(posedge clk);

		$display("Covered %0d beats and %0d checked results over %0d register settings;",
			beats_sent, results_checked, settings_used);
		$display("  %0d parity drops and %0d receives into a full FIFO.", parity_drops,
			full_hits);
		if (fail_count == 0) begin
			$display("uart_rx_fifo_parity_filter_top_test: PASS");
		end else begin
			$display("uart_rx_fifo_parity_filter_top_test: FAIL");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#4ms;
		$display("uart_rx_fifo_parity_filter_top_test: FAIL");
		$finish;
	end

endmodule

// File: uart_rx_fifo_parity_filter_top.f
rtl/urxf_pkg.sv
rtl/uart_rx_fifo_parity_filter_top.sv
verif/uart_rx_fifo_parity_filter_top_test.sv
